// ===== src/tekd_pkg.sv =====
package tekd_pkg;

  localparam int CmdW  = 2;
  localparam int CharW = 8;
  localparam int LenW  = 4;

  typedef enum logic [CmdW-1:0] {
    CmdChar    = 2'd0,
    CmdPoll    = 2'd1,
    CmdTimeout = 2'd2,
    CmdNone    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ActReject = 2'd0,
    ActSave   = 2'd1,
    ActConv   = 2'd2
  } act_e;

  typedef struct packed {
    act_e             act;
    logic [CharW-1:0] res;
  } class_t;

  typedef struct packed {
    logic [LenW-1:0] seq_len;
    logic [LenW-1:0] replay_idx;
    logic            replaying;
  } status_t;

  localparam logic [CharW-1:0] ChNul  = 8'h00;
  localparam logic [CharW-1:0] ChEsc  = 8'h1B;
  localparam logic [CharW-1:0] ChLf   = 8'h0A;
  localparam logic [CharW-1:0] ChCr   = 8'h0D;
  localparam logic [CharW-1:0] ChLbrk = 8'h5B;
  localparam logic [CharW-1:0] ChO    = 8'h4F;
  localparam logic [CharW-1:0] ChA    = 8'h41;
  localparam logic [CharW-1:0] ChB    = 8'h42;
  localparam logic [CharW-1:0] ChC    = 8'h43;
  localparam logic [CharW-1:0] ChD    = 8'h44;
  localparam logic [CharW-1:0] ChF    = 8'h46;
  localparam logic [CharW-1:0] ChH    = 8'h48;
  localparam logic [CharW-1:0] ChTild = 8'h7E;
  localparam logic [CharW-1:0] Ch0    = 8'h30;
  localparam logic [CharW-1:0] Ch1    = 8'h31;
  localparam logic [CharW-1:0] Ch2    = 8'h32;
  localparam logic [CharW-1:0] Ch3    = 8'h33;
  localparam logic [CharW-1:0] Ch4    = 8'h34;
  localparam logic [CharW-1:0] Ch7    = 8'h37;
  localparam logic [CharW-1:0] Ch8    = 8'h38;

  localparam logic [CharW-1:0] CtrlA = 8'h01;
  localparam logic [CharW-1:0] CtrlB = 8'h02;
  localparam logic [CharW-1:0] CtrlD = 8'h04;
  localparam logic [CharW-1:0] CtrlE = 8'h05;
  localparam logic [CharW-1:0] CtrlF = 8'h06;
  localparam logic [CharW-1:0] CtrlN = 8'h0E;
  localparam logic [CharW-1:0] CtrlP = 8'h10;

  function automatic class_t classify(logic [LenW-1:0] len, logic [CharW-1:0] ch,
                                      logic [CharW-1:0] s1, logic [CharW-1:0] s2);
    class_t c;
    c.act = ActReject;
    c.res = ch;
    case (len)
      4'd1: begin
        if (ch inside {ChLbrk, ChO}) c.act = ActSave;
      end
      4'd2: begin
        case (ch)
          ChD: begin c.act = ActConv; c.res = CtrlB; end
          ChC: begin c.act = ActConv; c.res = CtrlF; end
          ChH: begin c.act = ActConv; c.res = CtrlA; end
          ChF: begin c.act = ActConv; c.res = CtrlE; end
          ChA: begin c.act = ActConv; c.res = CtrlP; end
          ChB: begin c.act = ActConv; c.res = CtrlN; end
          Ch1, Ch2, Ch3, Ch4, Ch7, Ch8: begin
            if (s1 == ChLbrk) c.act = ActSave;
          end
          default: c.act = ActReject;
        endcase
      end
      4'd3: begin
        if (ch == ChTild) begin
          case (s2)
            Ch3:      begin c.act = ActConv; c.res = CtrlD; end
            Ch1, Ch7: begin c.act = ActConv; c.res = CtrlA; end
            Ch4, Ch8: begin c.act = ActConv; c.res = CtrlE; end
            default:  c.act = ActReject;
          endcase
        end else if (ch == Ch0 && s2 == Ch2) begin
          c.act = ActSave;
        end
      end
      4'd4: begin
        if (ch inside {Ch0, Ch1}) c.act = ActSave;
      end
      4'd5: begin
        if (ch == ChTild) begin
          c.act = ActConv;
          c.res = ChNul;
        end
      end
      default: c.act = ActReject;
    endcase
    return c;
  endfunction

endpackage

// ===== src/tekd_if.sv =====
interface tekd_in_if;
  logic                         valid;
  logic                         ready;
  logic [tekd_pkg::CmdW-1:0]    cmd;
  logic [tekd_pkg::CharW-1:0]   char_in;

  modport source (output valid, output cmd, output char_in, input ready);
  modport sink   (input valid, input cmd, input char_in, output ready);
endinterface

interface tekd_out_if;
  logic                         valid;
  logic                         ready;
  logic [tekd_pkg::CharW-1:0]   char_out;

  modport source (output valid, output char_out, input ready);
  modport sink   (input valid, input char_out, output ready);
endinterface

// ===== src/terminal_escape_key_decoder.sv =====
// terminal escape-key decoder
// input channel in_i carries one transaction per keyboard event: cmd selects
// byte arrival, replay poll or input timeout, char_in holds the byte
// output channel out_o returns exactly one char_out per input transaction,
// 0 meaning nothing to deliver; xterm escape sequences collapse into single
// control characters, rejected sequences start their replay at once and go on on later polls
// an accepted transaction waits in the input register and is decoded from there
// throughput: one transaction per cycle while out_o does not stall; the input
// register feeds the decode logic and the saved-byte array, whose state updates
// in the same cycle as the result lands in the output register
// reset clears the sequence length, replay index, replay flag and saved bytes
// and empties both registers
// when out_o stalls, the result holds in the output register, the input
// register keeps one more transaction, and in_i.ready drops only when both
// are full
module terminal_escape_key_decoder #(
  parameter int SAVE_DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tekd_in_if.sink     in_i,
  tekd_out_if.source  out_o
);

  localparam int LenW = tekd_pkg::LenW;
  localparam logic [LenW-1:0] LenCap = LenW'((SAVE_DEPTH < 15) ? SAVE_DEPTH : 15);

  logic                         in_vld_q;
  logic [tekd_pkg::CmdW-1:0]    cmd_q;
  logic [tekd_pkg::CharW-1:0]   char_q;
  logic                         out_vld_q;
  logic [tekd_pkg::CharW-1:0]   char_out_q;
  logic                         adv;
  logic [tekd_pkg::CharW-1:0]   res;
  tekd_pkg::status_t            status;

  assign adv        = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q  <= in_i.cmd;
      char_q <= in_i.char_in;
    end
  end

  tekd_core #(
    .SAVE_DEPTH(SAVE_DEPTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (adv),
    .cmd_i    (cmd_q),
    .char_i   (char_q),
    .char_o   (res),
    .status_o (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || out_o.ready) begin
      out_vld_q <= adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) char_out_q <= res;
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.char_out = char_out_q;

  a_adv_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q)
    else $error("decoded transaction did not reach the output register");

  a_accept_fills_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> in_vld_q)
    else $error("accepted transaction lost before decode");

  a_idle_poll_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !status.replaying && (cmd_q == tekd_pkg::CmdPoll))
      |=> (char_out_q == tekd_pkg::ChNul))
    else $error("poll without replay produced a character");

  a_counters_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status.seq_len <= LenCap) && (status.replay_idx <= LenCap))
    else $error("sequence counters beyond cap");

endmodule

// ===== src/tekd_core.sv =====
module tekd_core #(
  parameter int SAVE_DEPTH = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [tekd_pkg::CmdW-1:0]    cmd_i,
  input  logic [tekd_pkg::CharW-1:0]   char_i,
  output logic [tekd_pkg::CharW-1:0]   char_o,
  output tekd_pkg::status_t            status_o
);

  localparam int LenW = tekd_pkg::LenW;
  localparam int IdxW = $clog2(SAVE_DEPTH);
  localparam logic [LenW:0]   DepthV = (LenW+1)'(SAVE_DEPTH);
  localparam logic [LenW-1:0] LenCap = LenW'((SAVE_DEPTH < 15) ? SAVE_DEPTH : 15);

  logic [LenW-1:0]            seq_q, seq_d;
  logic [LenW-1:0]            ri_q, ri_d;
  logic                       rep_q, rep_d;
  logic [tekd_pkg::CharW-1:0] saved_q [SAVE_DEPTH];

  logic                       wr_en;
  logic [IdxW-1:0]            wr_idx;
  logic [tekd_pkg::CharW-1:0] wr_data;
  logic [LenW-1:0]            seq_inc, ri_inc;
  logic                       can_save, is_poll;
  logic [tekd_pkg::CharW-1:0] rd_raw;
  tekd_pkg::class_t           cls;

  assign seq_inc  = (seq_q < LenCap) ? seq_q + LenW'(1) : seq_q;
  assign ri_inc   = (ri_q < LenCap) ? ri_q + LenW'(1) : ri_q;
  assign can_save = ({1'b0, seq_q} < DepthV);
  assign rd_raw   = ({1'b0, ri_q} < DepthV) ? saved_q[ri_q[IdxW-1:0]] : tekd_pkg::ChNul;
  assign cls      = tekd_pkg::classify(seq_q, char_i, saved_q[1], saved_q[2]);
  assign is_poll  = (cmd_i == tekd_pkg::CmdPoll) ||
                    ((cmd_i == tekd_pkg::CmdChar) && (char_i == tekd_pkg::ChNul));

  always_comb begin
    seq_d   = seq_q;
    ri_d    = ri_q;
    rep_d   = rep_q;
    wr_en   = 1'b0;
    wr_idx  = seq_q[IdxW-1:0];
    wr_data = char_i;
    char_o  = tekd_pkg::ChNul;
    if (cmd_i == tekd_pkg::CmdNone) begin
      char_o = tekd_pkg::ChNul;
    end else if (is_poll) begin
      if (rep_q) begin
        if (ri_q < seq_q) begin
          char_o = rd_raw;
          ri_d   = ri_inc;
        end else begin
          ri_d  = '0;
          rep_d = 1'b0;
          seq_d = '0;
        end
      end
    end else if (cmd_i == tekd_pkg::CmdTimeout) begin
      if (seq_q != '0) begin
        seq_d  = '0;
        char_o = tekd_pkg::ChEsc;
      end
    end else if (char_i == tekd_pkg::ChLf || char_i == tekd_pkg::ChCr) begin
      char_o = tekd_pkg::ChLf;
    end else if (seq_q != '0) begin
      case (cls.act)
        tekd_pkg::ActSave: begin
          wr_en = can_save;
          seq_d = seq_inc;
        end
        tekd_pkg::ActReject: begin
          // save the offending byte if room remains, then replay from the saved sequence
          wr_en = can_save;
          seq_d = seq_inc;
          rep_d = 1'b1;
          ri_d  = ri_inc;
          if (ri_q < seq_inc) begin
            char_o = (can_save && ri_q == seq_q) ? char_i : rd_raw;
          end
        end
        default: begin
          seq_d  = '0;
          char_o = cls.res;
        end
      endcase
    end else if (char_i == tekd_pkg::ChEsc) begin
      wr_en   = 1'b1;
      wr_idx  = '0;
      wr_data = tekd_pkg::ChEsc;
      seq_d   = LenW'(1);
    end else begin
      char_o = char_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= '0;
      ri_q  <= '0;
      rep_q <= 1'b0;
      for (int i = 0; i < SAVE_DEPTH; i++) begin
        saved_q[i] <= '0;
      end
    end else if (step_i) begin
      seq_q <= seq_d;
      ri_q  <= ri_d;
      rep_q <= rep_d;
      if (wr_en) saved_q[wr_idx] <= wr_data;
    end
  end

  assign status_o.seq_len    = seq_q;
  assign status_o.replay_idx = ri_q;
  assign status_o.replaying  = rep_q;

endmodule

// ===== dv/tb_terminal_escape_key_decoder.sv =====
`timescale 1ns / 100ps

module tb_terminal_escape_key_decoder;

  localparam int CmdW        = tekd_pkg::CmdW;
  localparam int CharW       = tekd_pkg::CharW;
  localparam int LenW        = tekd_pkg::LenW;
  localparam int SaveDepth   = 8;
  localparam int LenCap      = (SaveDepth < 15) ? SaveDepth : 15;
  localparam int RandomItems = 550;
  localparam int DirRows     = 26;

  typedef struct {
    logic [CmdW-1:0]  cmd;
    logic [CharW-1:0] ch;
    bit               fixed;
    logic [CharW-1:0] want;
  } key_row_t;

  localparam logic [CharW-1:0] ArrowKeys [6] = '{tekd_pkg::ChA, tekd_pkg::ChB, tekd_pkg::ChC,
                                                 tekd_pkg::ChD, tekd_pkg::ChH, tekd_pkg::ChF};
  localparam logic [CharW-1:0] TildeKeys [6] = '{tekd_pkg::Ch1, tekd_pkg::Ch2, tekd_pkg::Ch3,
                                                 tekd_pkg::Ch4, tekd_pkg::Ch7, tekd_pkg::Ch8};

  // directed rows, typed-in expectations where obvious
  key_row_t dir_rows [DirRows] = '{
    '{tekd_pkg::CmdPoll,    tekd_pkg::ChNul,  1'b1, tekd_pkg::ChNul},
    '{tekd_pkg::CmdTimeout, tekd_pkg::ChNul,  1'b1, tekd_pkg::ChNul},
    '{tekd_pkg::CmdNone,    8'hFF,            1'b1, tekd_pkg::ChNul},
    '{tekd_pkg::CmdChar,    8'hFF,            1'b1, 8'hFF},
    '{tekd_pkg::CmdChar,    tekd_pkg::ChNul,  1'b1, tekd_pkg::ChNul},
    '{tekd_pkg::CmdChar,    tekd_pkg::ChCr,   1'b1, tekd_pkg::ChLf},
    '{tekd_pkg::CmdChar,    tekd_pkg::ChLf,   1'b1, tekd_pkg::ChLf},
    '{tekd_pkg::CmdChar,    tekd_pkg::ChEsc,  1'b0, tekd_pkg::ChNul},
    '{tekd_pkg::CmdChar,    tekd_pkg::ChLbrk, 1'b0, tekd_pkg::ChNul},
    '{tekd_pkg::CmdChar,    tekd_pkg::ChA,    1'b1, tekd_pkg::CtrlP},
    '{tekd_pkg::CmdChar,    tekd_pkg::ChEsc,  1'b0, tekd_pkg::ChNul},
    '{tekd_pkg::CmdChar,    tekd_pkg::ChLbrk, 1'b0, tekd_pkg::ChNul},
    '{tekd_pkg::CmdChar,    tekd_pkg::Ch3,    1'b0, tekd_pkg::ChNul},
    '{tekd_pkg::CmdChar,    tekd_pkg::ChTild, 1'b1, tekd_pkg::CtrlD},
    '{tekd_pkg::CmdChar,    tekd_pkg::ChEsc,  1'b0, tekd_pkg::ChNul},
    '{tekd_pkg::CmdChar,    tekd_pkg::ChLbrk, 1'b0, tekd_pkg::ChNul},
    '{tekd_pkg::CmdChar,    tekd_pkg::Ch2,    1'b0, tekd_pkg::ChNul},
    '{tekd_pkg::CmdChar,    tekd_pkg::Ch0,    1'b0, tekd_pkg::ChNul},
    '{tekd_pkg::CmdChar,    tekd_pkg::Ch1,    1'b0, tekd_pkg::ChNul},
    '{tekd_pkg::CmdChar,    tekd_pkg::ChTild, 1'b1, tekd_pkg::ChNul},
    '{tekd_pkg::CmdChar,    tekd_pkg::ChEsc,  1'b0, tekd_pkg::ChNul},
    '{tekd_pkg::CmdChar,    8'h78,            1'b0, tekd_pkg::ChNul},
    '{tekd_pkg::CmdPoll,    tekd_pkg::ChNul,  1'b0, tekd_pkg::ChNul},
    '{tekd_pkg::CmdPoll,    tekd_pkg::ChNul,  1'b0, tekd_pkg::ChNul},
    '{tekd_pkg::CmdChar,    tekd_pkg::ChEsc,  1'b0, tekd_pkg::ChNul},
    '{tekd_pkg::CmdTimeout, tekd_pkg::ChNul,  1'b1, tekd_pkg::ChEsc}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  tekd_in_if  in_if ();
  tekd_out_if out_if ();

  terminal_escape_key_decoder #(
    .SAVE_DEPTH(SaveDepth)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // decoder state mirror
  logic [LenW-1:0]  pend_len;
  logic [LenW-1:0]  pend_idx;
  logic             pend_replay;
  logic [CharW-1:0] seq_buf [SaveDepth];

  logic [CharW-1:0] char_q [$];
  logic [CharW-1:0] key_seq [$];
  logic [CharW-1:0] predicted;
  logic [CharW-1:0] want_char;
  logic             row_fixed;
  logic [CharW-1:0] row_want;

  int errors         = 0;
  int items_sent     = 0;
  int items_accepted = 0;
  int results_seen   = 0;
  int sequences      = 0;
  int burst_left     = 0;
  int sink_phase     = 0;

  function automatic logic [CharW-1:0] buf_at(input int i);
    return (i < SaveDepth) ? seq_buf[i] : tekd_pkg::ChNul;
  endfunction

  function automatic void stash(input logic [CharW-1:0] ch);
    if (pend_len < SaveDepth) seq_buf[pend_len] = ch;
    if (pend_len < LenCap) pend_len = pend_len + 1'b1;
  endfunction

  function automatic logic [CharW-1:0] next_replay();
    logic [CharW-1:0] v;
    v = tekd_pkg::ChNul;
    if (pend_idx < pend_len) v = buf_at(int'(pend_idx));
    if (pend_idx < LenCap) pend_idx = pend_idx + 1'b1;
    return v;
  endfunction

  function automatic logic [CharW-1:0] poll_replay();
    if (pend_replay) begin
      if (pend_idx < pend_len) return next_replay();
      pend_idx    = '0;
      pend_replay = 1'b0;
      pend_len    = '0;
    end
    return tekd_pkg::ChNul;
  endfunction

  function automatic tekd_pkg::act_e sort_byte(input logic [CharW-1:0] ch,
                                               output logic [CharW-1:0] conv);
    tekd_pkg::act_e act;
    act  = tekd_pkg::ActReject;
    conv = ch;
    case (pend_len)
      4'd1: if (ch == tekd_pkg::ChLbrk || ch == tekd_pkg::ChO) act = tekd_pkg::ActSave;
      4'd2: begin
        case (ch)
          tekd_pkg::ChD: begin act = tekd_pkg::ActConv; conv = tekd_pkg::CtrlB; end
          tekd_pkg::ChC: begin act = tekd_pkg::ActConv; conv = tekd_pkg::CtrlF; end
          tekd_pkg::ChH: begin act = tekd_pkg::ActConv; conv = tekd_pkg::CtrlA; end
          tekd_pkg::ChF: begin act = tekd_pkg::ActConv; conv = tekd_pkg::CtrlE; end
          tekd_pkg::ChA: begin act = tekd_pkg::ActConv; conv = tekd_pkg::CtrlP; end
          tekd_pkg::ChB: begin act = tekd_pkg::ActConv; conv = tekd_pkg::CtrlN; end
          tekd_pkg::Ch1, tekd_pkg::Ch2, tekd_pkg::Ch3, tekd_pkg::Ch4, tekd_pkg::Ch7,
          tekd_pkg::Ch8: if (buf_at(1) == tekd_pkg::ChLbrk) act = tekd_pkg::ActSave;
          default: act = tekd_pkg::ActReject;
        endcase
      end
      4'd3: begin
        if (ch == tekd_pkg::ChTild) begin
          case (buf_at(2))
            tekd_pkg::Ch3: begin act = tekd_pkg::ActConv; conv = tekd_pkg::CtrlD; end
            tekd_pkg::Ch1, tekd_pkg::Ch7: begin
              act  = tekd_pkg::ActConv;
              conv = tekd_pkg::CtrlA;
            end
            tekd_pkg::Ch4, tekd_pkg::Ch8: begin
              act  = tekd_pkg::ActConv;
              conv = tekd_pkg::CtrlE;
            end
            default: act = tekd_pkg::ActReject;
          endcase
        end else if (ch == tekd_pkg::Ch0 && buf_at(2) == tekd_pkg::Ch2) begin
          act = tekd_pkg::ActSave;
        end
      end
      4'd4: if (ch == tekd_pkg::Ch0 || ch == tekd_pkg::Ch1) act = tekd_pkg::ActSave;
      4'd5: if (ch == tekd_pkg::ChTild) begin
        act  = tekd_pkg::ActConv;
        conv = tekd_pkg::ChNul;
      end
      default: act = tekd_pkg::ActReject;
    endcase
    return act;
  endfunction

  function automatic logic [CharW-1:0] decode_key(input logic [CmdW-1:0] cmd,
                                                  input logic [CharW-1:0] ch);
    logic [CharW-1:0] r;
    logic [CharW-1:0] conv;
    bit               done;
    tekd_pkg::act_e   act;
    r    = tekd_pkg::ChNul;
    done = 1'b0;
    if (cmd == tekd_pkg::CmdNone) begin
      r = tekd_pkg::ChNul;
    end else if (cmd == tekd_pkg::CmdPoll ||
                 (cmd == tekd_pkg::CmdChar && ch == tekd_pkg::ChNul)) begin
      r = poll_replay();
    end else if (cmd == tekd_pkg::CmdTimeout) begin
      if (pend_len != 0) begin
        pend_len = '0;
        r        = tekd_pkg::ChEsc;
      end
    end else if (ch == tekd_pkg::ChLf || ch == tekd_pkg::ChCr) begin
      r = tekd_pkg::ChLf;
    end else begin
      r = ch;
      if (pend_len != 0) begin
        act = sort_byte(ch, conv);
        case (act)
          tekd_pkg::ActSave: begin
            stash(ch);
            r = tekd_pkg::ChNul;
          end
          tekd_pkg::ActReject: begin
            stash(ch);
            r           = next_replay();
            pend_replay = 1'b1;
            done        = 1'b1;
          end
          default: begin
            pend_len = '0;
            r        = conv;
          end
        endcase
      end
      if (!done && r == tekd_pkg::ChEsc) begin
        if (pend_len == 0) begin
          seq_buf[0] = tekd_pkg::ChEsc;
          pend_len   = 4'd1;
        end else begin
          pend_len = '0;
        end
        r = tekd_pkg::ChNul;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      predicted = decode_key(in_if.cmd, in_if.char_in);
      char_q.push_back(row_fixed ? row_want : predicted);
      items_accepted++;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (char_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected char_out, expected none, actual %02h", $time,
                 out_if.char_out);
      end else begin
        want_char = char_q.pop_front();
        if (out_if.char_out !== want_char) begin
          errors++;
          $display("%0t: char_out mismatch, expected %02h, actual %02h", $time, want_char,
                   out_if.char_out);
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk_i) begin
    sink_phase++;
    case (sink_phase[8:6])
      3'd0, 3'd1: out_if.ready <= 1'b1;
      3'd2:       out_if.ready <= 1'($urandom_range(0, 1));
      3'd3:       out_if.ready <= (sink_phase[2:0] < 3'd5);
      3'd4:       out_if.ready <= (sink_phase[3:0] >= 4'd12);
      default:    out_if.ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic send(input logic [CmdW-1:0] cmd, input logic [CharW-1:0] ch,
                      input bit fixed, input logic [CharW-1:0] want);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      gap        = $urandom_range(0, 6);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid   <= 1'b1;
    in_if.cmd     <= cmd;
    in_if.char_in <= ch;
    row_fixed     <= fixed;
    row_want      <= want;
    if (cmd != tekd_pkg::CmdNone) items_sent++;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic send_char(input logic [CharW-1:0] ch);
    send(tekd_pkg::CmdChar, ch, 1'b0, tekd_pkg::ChNul);
  endtask

  task automatic send_poll();
    send(tekd_pkg::CmdPoll, CharW'($urandom_range(0, 255)), 1'b0, tekd_pkg::ChNul);
  endtask

  task automatic wait_all_results();
    in_if.valid <= 1'b0;
    burst_left = 0;
    @(negedge clk_i);
    while (char_q.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic make_sequence(input int kind);
    key_seq.delete();
    key_seq.push_back(tekd_pkg::ChEsc);
    case (kind)
      0: begin
        key_seq.push_back($urandom_range(0, 1) ? tekd_pkg::ChLbrk : tekd_pkg::ChO);
        key_seq.push_back(ArrowKeys[$urandom_range(0, 5)]);
      end
      1: begin
        key_seq.push_back(tekd_pkg::ChLbrk);
        key_seq.push_back(TildeKeys[$urandom_range(0, 5)]);
        key_seq.push_back(tekd_pkg::ChTild);
      end
      default: begin
        key_seq.push_back(tekd_pkg::ChLbrk);
        key_seq.push_back(tekd_pkg::Ch2);
        key_seq.push_back(tekd_pkg::Ch0);
        key_seq.push_back($urandom_range(0, 1) ? tekd_pkg::Ch0 : tekd_pkg::Ch1);
        key_seq.push_back(tekd_pkg::ChTild);
      end
    endcase
  endtask

  initial begin
    int pick;
    int cut;
    in_if.valid   = 1'b0;
    in_if.cmd     = tekd_pkg::CmdNone;
    in_if.char_in = tekd_pkg::ChNul;
    row_fixed     = 1'b0;
    row_want      = tekd_pkg::ChNul;
    out_if.ready  = 1'b0;
    rst_ni        = 1'b0;
    pend_len      = '0;
    pend_idx      = '0;
    pend_replay   = 1'b0;
    foreach (seq_buf[i]) seq_buf[i] = tekd_pkg::ChNul;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      send(dir_rows[i].cmd, dir_rows[i].ch, dir_rows[i].fixed, dir_rows[i].want);
    end
    wait_all_results();

    while (items_sent < DirRows + RandomItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        make_sequence((pick < 20) ? 0 : (pick < 35) ? 1 : 2);
        foreach (key_seq[i]) send_char(key_seq[i]);
      end else if (pick < 80) begin
        // broken sequence, overflow when extra bytes land during replay
        make_sequence($urandom_range(0, 2));
        cut = $urandom_range(1, key_seq.size() - 1);
        for (int i = 0; i < cut; i++) send_char(key_seq[i]);
        send_char(CharW'($urandom_range(0, 255)));
        if (pick >= 70) repeat ($urandom_range(3, 10)) send_char(CharW'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 12)) send_poll();
      end else if (pick < 88) begin
        make_sequence($urandom_range(0, 2));
        cut = $urandom_range(1, (key_seq.size() - 1 < 4) ? key_seq.size() - 1 : 4);
        for (int i = 0; i < cut; i++) send_char(key_seq[i]);
        send(tekd_pkg::CmdTimeout, CharW'($urandom_range(0, 255)), 1'b0, tekd_pkg::ChNul);
        repeat ($urandom_range(0, 2)) send_poll();
      end else begin
        repeat ($urandom_range(1, 4)) send(CmdW'($urandom_range(0, 3)),
                                           CharW'($urandom_range(0, 255)), 1'b0,
                                           tekd_pkg::ChNul);
      end
      sequences++;
      if ($urandom_range(0, 39) == 0) wait_all_results();
    end

    wait_all_results();
    repeat (8) @(posedge clk_i);
    if (char_q.size() != 0) begin
      errors++;
      $display("%0t: results missing, expected %0d more, actual 0", $time, char_q.size());
    end

    $display("covered %0d input transactions in %0d random sequences, %0d results checked",
             items_accepted, sequences, results_seen);
    $display("arrow, tilde, paste, replay, overflow and timeout paths under gaps and stalls");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(4_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
src/tekd_pkg.sv
src/tekd_if.sv
src/tekd_core.sv
src/terminal_escape_key_decoder.sv
dv/tb_terminal_escape_key_decoder.sv
